FILE: sv/fspp_pkg.sv
package fspp_pkg;

  localparam int MAX_LEN_DEF = 128;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic KIND_PAYLOAD  = 1'b0;
  localparam logic KIND_COMPLETE = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_BODY    = 3'b010,
    PH_WAIT_LF = 3'b100
  } phase_t;

  typedef struct packed {
    logic              result_kind;
    logic              packet_kind;
    logic [7:0]        data_byte;
    logic [6:0]        byte_index;
    logic signed [7:0] number_value;
    logic [7:0]        packet_length;
    logic              overflow;
  } result_t;

endpackage

FILE: sv/fspp_parse.sv
module fspp_parse import fspp_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [7:0] MaxLen = 8'(MAX_LEN);

  phase_t     phase_r, phase_nxt;
  logic       is_number_r, is_number_nxt;
  logic [7:0] wc_r, wc_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       neg_r, neg_nxt;
  logic       dropped_r, dropped_nxt;
  logic [7:0] acc_step;
  logic [7:0] signed_val;

  // acc * 10 + (byte - '0'), mod 256
  assign acc_step = {acc_r[4:0], 3'b000} + {acc_r[6:0], 1'b0} + (rx_byte - CH_ZERO);
  assign signed_val = neg_r ? (8'd0 - acc_r) : acc_r;

  always_comb begin
    phase_nxt     = phase_r;
    is_number_nxt = is_number_r;
    wc_nxt        = wc_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    dropped_nxt   = dropped_r;
    res_valid     = 1'b0;
    res           = '0;
    res.packet_kind = is_number_r;

    unique case (phase_r)
      PH_BODY: begin
        if (rx_byte == CH_CR) begin
          phase_nxt = PH_WAIT_LF;
        end else if (wc_r >= MaxLen) begin
          dropped_nxt = 1'b1;
        end else begin
          if (is_number_r) begin
            if (wc_r == 8'd0 && rx_byte == CH_PLUS) begin
              neg_nxt = 1'b0;
            end else if (wc_r == 8'd0 && rx_byte == CH_MINUS) begin
              neg_nxt = 1'b1;
            end else begin
              acc_nxt = acc_step;
            end
          end
          res_valid       = 1'b1;
          res.result_kind = KIND_PAYLOAD;
          res.data_byte   = rx_byte;
          res.byte_index  = wc_r[6:0];
          wc_nxt          = wc_r + 8'd1;
        end
      end
      PH_WAIT_LF: begin
        if (rx_byte == CH_LF) begin
          phase_nxt         = PH_IDLE;
          res_valid         = 1'b1;
          res.result_kind   = KIND_COMPLETE;
          res.number_value  = is_number_r ? signed_val : 8'sd0;
          res.packet_length = wc_r;
          res.overflow      = dropped_r;
        end
      end
      default: begin
        // idle and any stray code
        phase_nxt = PH_IDLE;
        if (rx_byte == CH_AT || rx_byte == CH_DOLLAR) begin
          phase_nxt     = PH_BODY;
          is_number_nxt = (rx_byte == CH_DOLLAR);
          wc_nxt        = 8'd0;
          acc_nxt       = 8'd0;
          neg_nxt       = 1'b0;
          dropped_nxt   = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      is_number_r <= 1'b0;
      wc_r        <= 8'd0;
      acc_r       <= 8'd0;
      neg_r       <= 1'b0;
      dropped_r   <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      is_number_r <= is_number_nxt;
      wc_r        <= wc_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      dropped_r   <= dropped_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= MaxLen) else $error("body count beyond max length");

  a_payload_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.result_kind == KIND_PAYLOAD |-> phase_r == PH_BODY)
    else $error("payload word outside body");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.result_kind == KIND_COMPLETE |=> phase_r == PH_IDLE)
    else $error("completion did not return to idle");

  a_drop_held: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_BODY && rx_byte != CH_CR && wc_r == MaxLen |=> dropped_r)
    else $error("dropped byte not flagged");
`endif

endmodule

FILE: sv/fspp_out_reg.sv
module fspp_out_reg import fspp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load_valid,
  input  result_t load_res,
  input  logic    out_stall,
  output logic    free,
  output logic    out_valid,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  // slot can take a new word when empty or being drained this cycle
  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule

FILE: sv/framed_serial_packet_parser.sv
// framed serial packet parser
// in channel: one received serial byte per word (in_rx_byte), in_valid / in_stall
// out channel: one result word per payload byte or completed packet, out_valid /
//   out_stall; out_result_kind tells which, the other fields are zero when unused
// a packet is '@' (text) or '$' (number), body bytes, CR, then LF
// path: a taken byte waits in the input stage until the output register is free,
//   then the parser processes it and its result is loaded into the output register
// throughput: one byte per cycle while out_stall is low, set by the single update
//   of the parser state between the input stage and the output register
// bytes that cause no result (idle noise, CR, bytes while waiting for LF, bytes
//   beyond the length limit) are consumed by the parser and show nothing
// stall: a held output word blocks the parser; an empty input stage still takes one
//   more byte, after which in_stall rises until out_stall drops
// reset: synchronous active-low rst_n, parser returns to idle, both stages empty
module framed_serial_packet_parser import fspp_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_result_kind,
  output logic              out_packet_kind,
  output logic [7:0]        out_data_byte,
  output logic [6:0]        out_byte_index,
  output logic signed [7:0] out_number_value,
  output logic [7:0]        out_packet_length,
  output logic              out_overflow
);

  // input stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       in_take;

  // parser / output register handshake
  logic    out_free;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign step     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // frame state and per-byte result
  fspp_parse #(
    .MAX_LEN (MAX_LEN)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  fspp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (step && res_valid),
    .load_res   (res),
    .out_stall  (out_stall),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

  assign out_result_kind   = out_res.result_kind;
  assign out_packet_kind   = out_res.packet_kind;
  assign out_data_byte     = out_res.data_byte;
  assign out_byte_index    = out_res.byte_index;
  assign out_number_value  = out_res.number_value;
  assign out_packet_length = out_res.packet_length;
  assign out_overflow      = out_res.overflow;

endmodule
